@@ rtl/pihs_pkg.sv @@
`timescale 1ns / 1ps
package pihs_pkg;

   typedef enum logic [1:0] {
      SHAPE_CAPSULE = 2'd0,
      SHAPE_ARC     = 2'd1,
      SHAPE_CHAIN   = 2'd2,
      SHAPE_NONE    = 2'd3
   } shape_kind_type;

   typedef enum logic [2:0] {
      CSR_SHAPE_KIND   = 3'd0,
      CSR_OUTER_RADIUS = 3'd1,
      CSR_INNER_RADIUS = 3'd2,
      CSR_ARC_START    = 3'd3,
      CSR_ARC_END      = 3'd4,
      CSR_VERTEX_COUNT = 3'd5
   } csr_index_type;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TEST  = 1'b1;

   typedef enum logic [2:0] {
      T_IDLE,
      T_LDA,
      T_LDB,
      T_SEG,
      T_COR,
      T_ANG,
      T_FIN
   } top_state_type;

   typedef enum logic [2:0] {
      SEG_IDLE,
      SEG_MAC,
      SEG_PICK,
      SEG_WIDE,
      SEG_DONE
   } seg_state_type;

   typedef struct packed {
      logic done;
      logic hit;
   } seg_status_type;

   localparam logic [3:0] CORDIC_LAST = 4'd14;

   localparam logic signed [17:0] ZA_ZERO    = 18'sd0;
   localparam logic signed [17:0] ZA_QUARTER = 18'sd16384;
   localparam logic signed [17:0] ZA_HALF    = 18'sd32768;

   // Arctangent of 2^-i in binary angle units.
   function automatic logic [13:0] atan_step(input logic [3:0] i);
      logic [13:0] v;
      case (i)
         4'd0:  v = 14'd8192;
         4'd1:  v = 14'd4836;
         4'd2:  v = 14'd2555;
         4'd3:  v = 14'd1297;
         4'd4:  v = 14'd651;
         4'd5:  v = 14'd326;
         4'd6:  v = 14'd163;
         4'd7:  v = 14'd81;
         4'd8:  v = 14'd41;
         4'd9:  v = 14'd20;
         4'd10: v = 14'd10;
         4'd11: v = 14'd5;
         4'd12: v = 14'd3;
         4'd13: v = 14'd1;
         4'd14: v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

   // Folds a 16-bit binary angle into (-half turn, half turn].
   function automatic logic signed [16:0] wrap_angle(input logic [15:0] w);
      logic signed [16:0] v;
      if (w == 16'h8000) begin
         v = 17'sd32768;
      end else begin
         v = 17'(signed'(w));
      end
      return v;
   endfunction

endpackage

@@ rtl/pihs_ram.sv @@
`timescale 1ns / 1ps
module pihs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pihs_seg.sv @@
`timescale 1ns / 1ps
module pihs_seg import pihs_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   input  logic [31:0]                  r2,
   output seg_status_type               status,
   output logic [2*COORD_BITS+1:0]      sq_dist
);

   localparam int L   = COORD_BITS + 1;
   localparam int S   = 2 * COORD_BITS + 3;
   localparam int MW  = S - 1;
   localparam int KW  = (MW > 32) ? MW : 32;
   localparam int ND  = (KW + 7) / 8;
   localparam int BW  = 8 * ND;
   localparam int AW  = MW + BW;
   localparam int DCW = $clog2(ND + 1);
   localparam logic [3:0] LAST_STEP = 4'd9;

   seg_state_type state_ff, state_in;

   logic [3:0]           step_ff;
   logic signed [S-1:0]  acc_ff, n_ff, len2_ff, dw_ff, de_ff, c_ff;
   logic                 hit_ff, wide_ff;
   logic [BW-1:0]        b1_ff, b2_ff;
   logic [AW-1:0]        acc1_ff, acc2_ff;
   logic [MW-1:0]        a1_ff, a2_ff;
   logic [DCW-1:0]       dig_ff;

   logic signed [L-1:0]   vx, vy, wx, wy, ex, ey, op_a, op_b;
   logic signed [2*L-1:0] prod;
   logic signed [S-1:0]   sum;
   logic                  first, neg;
   logic                  near_a, near_b, need_wide;
   logic [MW-1:0]         c_mag;
   logic [MW+7:0]         p1, p2;

   assign vx = L'(bx) - L'(ax);
   assign vy = L'(by) - L'(ay);
   assign wx = L'(px) - L'(ax);
   assign wy = L'(py) - L'(ay);
   assign ex = L'(px) - L'(bx);
   assign ey = L'(py) - L'(by);

   // Ten multiply-accumulate steps give the dot product, the squared lengths
   // and the cross product.
   always_comb begin
      op_a  = wx;
      op_b  = vx;
      first = 1'b0;
      neg   = 1'b0;
      case (step_ff)
         4'd0: begin op_a = wx; op_b = vx; first = 1'b1; end
         4'd1: begin op_a = wy; op_b = vy; end
         4'd2: begin op_a = vx; op_b = vx; first = 1'b1; end
         4'd3: begin op_a = vy; op_b = vy; end
         4'd4: begin op_a = wx; op_b = wx; first = 1'b1; end
         4'd5: begin op_a = wy; op_b = wy; end
         4'd6: begin op_a = ex; op_b = ex; first = 1'b1; end
         4'd7: begin op_a = ey; op_b = ey; end
         4'd8: begin op_a = wx; op_b = vy; first = 1'b1; end
         4'd9: begin op_a = wy; op_b = vx; neg = 1'b1; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign prod = op_a * op_b;
   assign sum  = (first ? S'(0) : acc_ff) + (neg ? -S'(prod) : S'(prod));

   assign near_a    = (len2_ff == '0) || n_ff[S-1] || (n_ff == '0);
   assign near_b    = (n_ff >= len2_ff);
   assign need_wide = !near_a && !near_b;
   assign c_mag     = c_ff[S-1] ? MW'(-c_ff) : MW'(c_ff);

   assign p1 = a1_ff * b1_ff[BW-1 -: 8];
   assign p2 = a2_ff * b2_ff[BW-1 -: 8];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEG_IDLE: if (start) state_in = SEG_MAC;
         SEG_MAC:  if (step_ff == LAST_STEP) state_in = SEG_PICK;
         SEG_PICK: state_in = need_wide ? SEG_WIDE : SEG_DONE;
         SEG_WIDE: if (dig_ff == DCW'(ND - 1)) state_in = SEG_DONE;
         SEG_DONE: state_in = SEG_IDLE;
         default:  state_in = SEG_IDLE;
      endcase
   end

   always_comb begin
      status.done = (state_ff == SEG_DONE);
      status.hit  = wide_ff ? (acc1_ff <= acc2_ff) : hit_ff;
      sq_dist     = dw_ff[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         SEG_IDLE: begin
            step_ff <= '0;
         end
         SEG_MAC: begin
            acc_ff  <= sum;
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'd1) n_ff <= sum;
            if (step_ff == 4'd3) len2_ff <= sum;
            if (step_ff == 4'd5) dw_ff <= sum;
            if (step_ff == 4'd7) de_ff <= sum;
            if (step_ff == LAST_STEP) c_ff <= sum;
         end
         SEG_PICK: begin
            wide_ff <= need_wide;
            if (near_a) begin
               hit_ff <= KW'(dw_ff[MW-1:0]) <= KW'(r2);
            end else begin
               hit_ff <= KW'(de_ff[MW-1:0]) <= KW'(r2);
            end
            // Inside the span the test is cross^2 <= r^2 * len^2, taken a byte per cycle.
            a1_ff   <= c_mag;
            b1_ff   <= BW'(c_mag);
            a2_ff   <= len2_ff[MW-1:0];
            b2_ff   <= BW'(r2);
            acc1_ff <= '0;
            acc2_ff <= '0;
            dig_ff  <= '0;
         end
         SEG_WIDE: begin
            acc1_ff <= (acc1_ff << 8) + AW'(p1);
            acc2_ff <= (acc2_ff << 8) + AW'(p2);
            b1_ff   <= b1_ff << 8;
            b2_ff   <= b2_ff << 8;
            dig_ff  <= dig_ff + DCW'(1);
         end
         SEG_DONE: begin
            step_ff <= '0;
         end
         default: begin
            step_ff <= '0;
         end
      endcase
   end

endmodule

@@ rtl/point_in_hit_shape_test_core.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Beat contents
// req      in         command, vertex_index, point_x, point_y
// rsp      out        hit, was_query
// csr      in         index, wdata (register write, always ready)
//
// A query accepts the point, fetches vertex 0, tests each segment in turn and
// loads the result; a segment takes longer when the point projects inside the
// span (byte-serial wide product). An arc skips the angle iterations on an axis
// through vertex 0, and skips the angle test as well outside the ring.
// Reset clears control state and the registers, not the vertex memory. A result
// still waiting at the output holds the next item in its last cycle until it leaves.
module point_in_hit_shape_test_core import pihs_pkg::*; #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [3:0]                   req_vertex_index,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic                         rsp_was_query,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [15:0]                  csr_wdata
);

   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int NW   = AW + 1;
   localparam int L    = COORD_BITS + 1;
   localparam int MW   = 2 * COORD_BITS + 2;
   localparam int KW   = (MW > 32) ? MW : 32;
   localparam int XW   = COORD_BITS + 12;
   localparam int VW   = 2 * COORD_BITS;

   top_state_type  state_ff, state_in;
   shape_kind_type shape_kind_ff;
   logic [15:0]    outer_radius_ff, inner_radius_ff, arc_start_ff, arc_end_ff;
   logic [4:0]     vertex_count_ff;
   logic [31:0]    ro2_ff, ri2_ff;

   logic signed [COORD_BITS-1:0] px_ff, py_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic [NW-1:0]  n_ff, idx_ff;
   logic           res_hit_ff, res_query_ff;
   logic           rsp_valid_ff, rsp_hit_ff, rsp_was_query_ff;
   logic signed [XW-1:0] cx_ff, cy_ff;
   logic signed [17:0]   cz_ff;
   logic [3:0]     cit_ff;

   logic           req_fire, fin_load, mem_we, rd_en, seg_start;
   logic [AW-1:0]  rd_addr;
   logic [VW-1:0]  rd_data;
   logic signed [COORD_BITS-1:0] rd_x, rd_y;
   logic [NW-1:0]  n_sat, q_count, idx_next;
   logic           more_segs, in_ring, win;
   seg_status_type seg_status;
   logic [MW-1:0]  seg_dist;
   logic signed [L-1:0]  dx_c, dy_c;
   logic signed [XW-1:0] x0, y0, cx_sh, cy_sh;
   logic signed [17:0]   za;
   logic signed [16:0]   ang, a0, a1;

   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rd_x      = rd_data[VW-1:COORD_BITS];
   assign rd_y      = rd_data[COORD_BITS-1:0];

   assign n_sat = (32'(vertex_count_ff) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                        : NW'(vertex_count_ff);
   always_comb begin
      unique case (shape_kind_ff)
         SHAPE_CAPSULE: q_count = NW'(2);
         SHAPE_ARC:     q_count = NW'(1);
         SHAPE_CHAIN:   q_count = n_sat;
         SHAPE_NONE:    q_count = '0;
         default:       q_count = '0;
      endcase
   end

   assign idx_next  = idx_ff + NW'(1);
   assign more_segs = idx_next < n_ff;
   assign in_ring   = (KW'(seg_dist) <= KW'(ro2_ff)) && (KW'(seg_dist) >= KW'(ri2_ff));

   // Angle of the point around vertex 0; quarter turns are resolved before the iterations.
   assign dx_c  = L'(px_ff) - L'(ax_ff);
   assign dy_c  = L'(py_ff) - L'(ay_ff);
   assign x0    = XW'(dx_c) <<< 8;
   assign y0    = XW'(dy_c) <<< 8;
   assign cx_sh = cx_ff >>> cit_ff;
   assign cy_sh = cy_ff >>> cit_ff;
   assign za    = 18'(atan_step(cit_ff));

   assign ang = wrap_angle(cz_ff[15:0]);
   assign a0  = wrap_angle(arc_start_ff);
   assign a1  = wrap_angle(arc_end_ff);
   assign win = (a0 <= a1) ? ((ang >= a0) && (ang <= a1)) : ((ang >= a0) || (ang <= a1));

   pihs_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(req_vertex_index)),
      .wr_data ({req_point_x, req_point_y}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pihs_seg #(
      .COORD_BITS (COORD_BITS)
   ) u_seg (
      .clock   (clock),
      .reset   (reset),
      .start   (seg_start),
      .ax      (ax_ff),
      .ay      (ay_ff),
      .bx      (bx_ff),
      .by      (by_ff),
      .px      (px_ff),
      .py      (py_ff),
      .r2      (ro2_ff),
      .status  (seg_status),
      .sq_dist (seg_dist)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (req_fire) begin
               if (req_command == CMD_WRITE || q_count == '0) begin
                  state_in = T_FIN;
               end else begin
                  state_in = T_LDA;
               end
            end
         end
         T_LDA: state_in = (n_ff == NW'(1)) ? T_SEG : T_LDB;
         T_LDB: state_in = T_SEG;
         T_SEG: begin
            if (seg_status.done) begin
               if (shape_kind_ff == SHAPE_ARC) begin
                  if (!in_ring) begin
                     state_in = T_FIN;
                  end else if (dx_c == '0 || dy_c == '0) begin
                     state_in = T_ANG;
                  end else begin
                     state_in = T_COR;
                  end
               end else if (seg_status.hit || !more_segs) begin
                  state_in = T_FIN;
               end else begin
                  state_in = T_LDB;
               end
            end
         end
         T_COR:   if (cit_ff == CORDIC_LAST) state_in = T_ANG;
         T_ANG:   state_in = T_FIN;
         T_FIN:   if (fin_load) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == T_IDLE);
      fin_load  = (state_ff == T_FIN) && (!rsp_valid_ff || rsp_ready);
      mem_we    = req_fire && (req_command == CMD_WRITE)
                  && (32'(req_vertex_index) < MAX_VERTICES);
      rd_en     = 1'b0;
      rd_addr   = '0;
      seg_start = 1'b0;
      unique case (state_ff)
         T_IDLE: rd_en = req_fire && (req_command == CMD_TEST);
         T_LDA: begin
            if (n_ff == NW'(1)) begin
               seg_start = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(1);
            end
         end
         T_LDB: seg_start = 1'b1;
         T_SEG: begin
            rd_en   = seg_status.done && (shape_kind_ff != SHAPE_ARC)
                      && !seg_status.hit && more_segs;
            rd_addr = idx_next[AW-1:0];
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= T_IDLE;
         shape_kind_ff   <= SHAPE_NONE;
         outer_radius_ff <= '0;
         inner_radius_ff <= '0;
         arc_start_ff    <= '0;
         arc_end_ff      <= '0;
         vertex_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SHAPE_KIND:   shape_kind_ff   <= shape_kind_type'(csr_wdata[1:0]);
               CSR_OUTER_RADIUS: outer_radius_ff <= csr_wdata;
               CSR_INNER_RADIUS: inner_radius_ff <= csr_wdata;
               CSR_ARC_START:    arc_start_ff    <= csr_wdata;
               CSR_ARC_END:      arc_end_ff      <= csr_wdata;
               CSR_VERTEX_COUNT: vertex_count_ff <= csr_wdata[4:0];
               default:          vertex_count_ff <= vertex_count_ff;
            endcase
         end
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ro2_ff <= outer_radius_ff * outer_radius_ff;
      ri2_ff <= inner_radius_ff * inner_radius_ff;
      if (fin_load) begin
         rsp_hit_ff       <= res_hit_ff;
         rsp_was_query_ff <= res_query_ff;
      end
      unique case (state_ff)
         T_IDLE: begin
            if (req_fire) begin
               px_ff        <= req_point_x;
               py_ff        <= req_point_y;
               res_query_ff <= (req_command == CMD_TEST);
               res_hit_ff   <= 1'b0;
               n_ff         <= q_count;
               idx_ff       <= '0;
            end
         end
         T_LDA: begin
            ax_ff  <= rd_x;
            ay_ff  <= rd_y;
            bx_ff  <= rd_x;
            by_ff  <= rd_y;
            idx_ff <= NW'(1);
         end
         T_LDB: begin
            bx_ff <= rd_x;
            by_ff <= rd_y;
         end
         T_SEG: begin
            if (seg_status.done) begin
               if (shape_kind_ff == SHAPE_ARC) begin
                  cit_ff <= '0;
                  if (dy_c == '0) begin
                     cz_ff <= dx_c[L-1] ? ZA_HALF : ZA_ZERO;
                  end else if (dx_c == '0) begin
                     cz_ff <= dy_c[L-1] ? -ZA_QUARTER : ZA_QUARTER;
                  end else if (!dx_c[L-1]) begin
                     cx_ff <= x0;
                     cy_ff <= y0;
                     cz_ff <= ZA_ZERO;
                  end else if (!dy_c[L-1]) begin
                     cx_ff <= y0;
                     cy_ff <= -x0;
                     cz_ff <= ZA_QUARTER;
                  end else begin
                     cx_ff <= -y0;
                     cy_ff <= x0;
                     cz_ff <= -ZA_QUARTER;
                  end
               end else if (seg_status.hit) begin
                  res_hit_ff <= 1'b1;
               end else begin
                  // The end of this segment starts the next one.
                  ax_ff  <= bx_ff;
                  ay_ff  <= by_ff;
                  idx_ff <= idx_next;
               end
            end
         end
         T_COR: begin
            if (!cy_ff[XW-1] && cy_ff != '0) begin
               cx_ff <= cx_ff + cy_sh;
               cy_ff <= cy_ff - cx_sh;
               cz_ff <= cz_ff + za;
            end else begin
               cx_ff <= cx_ff - cy_sh;
               cy_ff <= cy_ff + cx_sh;
               cz_ff <= cz_ff - za;
            end
            cit_ff <= cit_ff + 4'd1;
         end
         T_ANG: begin
            res_hit_ff <= win;
         end
         T_FIN: begin
            cit_ff <= '0;
         end
         default: begin
            cit_ff <= '0;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_was_query = rsp_was_query_ff;

endmodule

@@ bench/point_in_hit_shape_test_checker.sv @@
`timescale 1ns / 1ps
module point_in_hit_shape_test_checker import pihs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_command,
   input  logic [3:0]         req_vertex_index,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_hit,
   input  logic               rsp_was_query,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output int                 errors,
   output int                 pending
);

   typedef struct packed {
      logic hit;
      logic was_query;
   } outcome_type;

   outcome_type outcomes[$];

   logic signed [15:0] vtx_x [16];
   logic signed [15:0] vtx_y [16];
   shape_kind_type     kind;
   logic [15:0]        r_outer;
   logic [15:0]        r_inner;
   logic [15:0]        ang_lo;
   logic [15:0]        ang_hi;
   logic [4:0]         n_vertices;

   int step_angle [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

   initial begin
      errors  = 0;
      pending = 0;
   end

   function automatic longint sq_len(longint dx, longint dy);
      return dx * dx + dy * dy;
   endfunction

   // Distance to the segment is compared without division: the squared cross
   // product against r^2 times the squared segment length.
   function automatic logic near_segment(longint ax, longint ay, longint bx, longint by,
                                         longint x, longint y, longint r2);
      longint      vx, vy, wx, wy, dot, len2, cr;
      logic [127:0] c2, lim;
      vx   = bx - ax;
      vy   = by - ay;
      wx   = x - ax;
      wy   = y - ay;
      dot  = wx * vx + wy * vy;
      len2 = sq_len(vx, vy);
      if (len2 == 0 || dot <= 0) return sq_len(wx, wy) <= r2;
      if (dot >= len2) return sq_len(x - bx, y - by) <= r2;
      cr = wx * vy - wy * vx;
      if (cr < 0) cr = -cr;
      c2  = 128'(cr) * 128'(cr);
      lim = 128'(r2) * 128'(len2);
      return c2 <= lim;
   endfunction

   function automatic int fold_angle(logic [15:0] w);
      if (w == 16'h8000) return 32768;
      return int'(signed'(w));
   endfunction

   function automatic int bearing(longint dx, longint dy);
      longint x, y, t, xs, ys;
      int     z;
      z = 0;
      if (dy == 0) return (dx >= 0) ? 0 : 32768;
      if (dx == 0) return (dy > 0) ? 16384 : -16384;
      x = dx * 256;
      y = dy * 256;
      // Rotate the left half plane by a quarter turn before the iterations.
      if (x < 0) begin
         if (y > 0) begin
            t = x; x = y; y = -t; z = 16384;
         end else begin
            t = x; x = -y; y = t; z = -16384;
         end
      end
      for (int i = 0; i < 15; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z += step_angle[i];
         end else begin
            x = x - ys; y = y + xs; z -= step_angle[i];
         end
      end
      return fold_angle(z[15:0]);
   endfunction

   function automatic logic in_ring_sector(longint x, longint y);
      longint dx, dy, d2;
      int     a, lo, hi;
      dx = x - vtx_x[0];
      dy = y - vtx_y[0];
      d2 = sq_len(dx, dy);
      if (d2 > longint'(r_outer) * longint'(r_outer)) return 1'b0;
      if (d2 < longint'(r_inner) * longint'(r_inner)) return 1'b0;
      a  = bearing(dx, dy);
      lo = fold_angle(ang_lo);
      hi = fold_angle(ang_hi);
      if (lo <= hi) return a >= lo && a <= hi;
      return a >= lo || a <= hi;
   endfunction

   function automatic logic shape_hit(longint x, longint y);
      longint r2;
      int     n;
      r2 = longint'(r_outer) * longint'(r_outer);
      case (kind)
         SHAPE_CAPSULE: return near_segment(vtx_x[0], vtx_y[0], vtx_x[1], vtx_y[1], x, y, r2);
         SHAPE_ARC:     return in_ring_sector(x, y);
         SHAPE_CHAIN: begin
            n = (n_vertices > 16) ? 16 : n_vertices;
            if (n == 0) return 1'b0;
            if (n == 1) return sq_len(x - vtx_x[0], y - vtx_y[0]) <= r2;
            for (int i = 0; i + 1 < n; i++)
               if (near_segment(vtx_x[i], vtx_y[i], vtx_x[i+1], vtx_y[i+1], x, y, r2))
                  return 1'b1;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Handshakes are sampled at the falling edge, before the rising edge that
   // completes them.
   always @(negedge clock) begin
      outcome_type want, got;
      if (reset) begin
         kind       = SHAPE_NONE;
         r_outer    = '0;
         r_inner    = '0;
         ang_lo     = '0;
         ang_hi     = '0;
         n_vertices = '0;
         outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SHAPE_KIND:   kind = shape_kind_type'(csr_wdata[1:0]);
               CSR_OUTER_RADIUS: r_outer = csr_wdata;
               CSR_INNER_RADIUS: r_inner = csr_wdata;
               CSR_ARC_START:    ang_lo = csr_wdata;
               CSR_ARC_END:      ang_hi = csr_wdata;
               CSR_VERTEX_COUNT: n_vertices = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_command == CMD_WRITE) begin
               vtx_x[req_vertex_index] = req_point_x;
               vtx_y[req_vertex_index] = req_point_y;
               outcomes.push_back('{hit: 1'b0, was_query: 1'b0});
            end else begin
               outcomes.push_back('{hit: shape_hit(req_point_x, req_point_y), was_query: 1'b1});
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{hit: rsp_hit, was_query: rsp_was_query};
            if (outcomes.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat: expected none, actual hit %0b was_query %0b",
                        $time, got.hit, got.was_query);
            end else begin
               want = outcomes.pop_front();
               if (got.hit !== want.hit) begin
                  errors++;
                  $display("%0t: hit mismatch: expected %0b, actual %0b",
                           $time, want.hit, got.hit);
               end
               if (got.was_query !== want.was_query) begin
                  errors++;
                  $display("%0t: was_query mismatch: expected %0b, actual %0b",
                           $time, want.was_query, got.was_query);
               end
            end
         end
      end
      pending = outcomes.size();
   end

endmodule

@@ bench/point_in_hit_shape_test_core_tb.sv @@
`timescale 1ns / 1ps
module point_in_hit_shape_test_core_tb;
   import pihs_pkg::*;

   localparam int SETTLE_CYCLES = 320;
   localparam int STALL_LIMIT   = 3000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_command;
   logic [3:0]         req_vertex_index;
   logic signed [15:0] req_point_x;
   logic signed [15:0] req_point_y;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_hit;
   logic               rsp_was_query;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;
   int                 errors;
   int                 pending;

   int                 items;
   logic               calm;
   int                 shadow_x [16];
   int                 shadow_y [16];
   int                 idle_cycles;

   point_in_hit_shape_test_core uut (.*);

   point_in_hit_shape_test_checker checker_i (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int pause_len();
      if (calm || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic signed [15:0] clamp(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   function automatic logic signed [15:0] rand_coord();
      if ($urandom_range(0, 5) == 0) return 16'($urandom);
      return clamp(int'($urandom_range(0, 8000)) - 4000);
   endfunction

   function automatic logic [15:0] pick_radius();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 3000));
      endcase
   endfunction

   task automatic offer(logic cmd, logic [3:0] idx, logic signed [15:0] x, logic signed [15:0] y);
      int   gap;
      logic took;
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_vertex_index <= idx;
      req_point_x      <= x;
      req_point_y      <= y;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      items++;
   endtask

   task automatic put_vertex(int i, logic signed [15:0] x, logic signed [15:0] y);
      shadow_x[i] = x;
      shadow_y[i] = y;
      offer(CMD_WRITE, 4'(i), x, y);
   endtask

   task automatic query(logic signed [15:0] x, logic signed [15:0] y);
      offer(CMD_TEST, 4'($urandom_range(0, 15)), x, y);
   endtask

   task automatic set_reg(csr_index_type i, logic [15:0] d);
      logic took;
      csr_valid <= 1'b1;
      csr_index <= i;
      csr_wdata <= d;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
   endtask

   // Registers change only once every outstanding beat has come back.
   task automatic configure(shape_kind_type k, logic [15:0] ro, logic [15:0] ri,
                            logic [15:0] a0, logic [15:0] a1, logic [4:0] vc);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      set_reg(CSR_SHAPE_KIND, 16'(k));
      set_reg(CSR_OUTER_RADIUS, ro);
      set_reg(CSR_INNER_RADIUS, ri);
      set_reg(CSR_ARC_START, a0);
      set_reg(CSR_ARC_END, a1);
      set_reg(CSR_VERTEX_COUNT, 16'(vc));
      csr_valid <= 1'b0;
   endtask

   initial begin
      shape_kind_type k;
      logic [15:0]    ro, ri;
      logic [4:0]     vc;
      int             span, v, cx, cy;
      items = 0;
      calm  = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_command      <= CMD_WRITE;
      req_vertex_index <= '0;
      req_point_x      <= '0;
      req_point_y      <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_SHAPE_KIND;
      csr_wdata        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The whole vertex table is written before any query reads it.
      put_vertex(0, 0, 0);
      put_vertex(1, 0, 0);
      put_vertex(2, 16'sh7FFF, 16'sh7FFF);
      put_vertex(3, 16'sh8000, 16'sh8000);
      for (int i = 4; i < 16; i++) put_vertex(i, rand_coord(), rand_coord());
      query(16'sh7FFF, 16'sh8000);

      // Degenerate segment and boundary distance.
      configure(SHAPE_CAPSULE, 16, 0, 0, 0, 0);
      query(16, 0);
      query(17, 0);
      query(0, -16);

      // Wrapped window starting at the half turn; centre and axis points.
      configure(SHAPE_ARC, 16'hFFFF, 0, 16'h8000, 16'h4000, 0);
      query(0, 0);
      query(100, 0);
      query(0, 100);
      query(-100, 0);
      query(0, -100);
      query(70, -70);

      // Count above the table size saturates; extreme vertices.
      configure(SHAPE_CHAIN, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8001, 5'd31);
      query(16'sh8000, 16'sh7FFF);
      query(16'sh7FFF, 16'sh7FFF);
      configure(SHAPE_CHAIN, 100, 0, 0, 0, 0);
      query(0, 0);
      configure(SHAPE_CHAIN, 100, 0, 0, 0, 1);
      query(100, 0);
      query(101, 0);
      configure(SHAPE_CAPSULE, 0, 0, 0, 0, 16);
      put_vertex(1, 160, 0);
      query(80, 0);
      query(80, 1);

      while (items < 1150) begin
         calm = ($urandom_range(0, 3) == 0);
         k  = ($urandom_range(0, 7) == 0) ? SHAPE_NONE : shape_kind_type'($urandom_range(0, 2));
         ro = pick_radius();
         ri = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, ro));
         vc = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                          : 5'($urandom_range(0, 16));
         configure(k, ro, ri, 16'($urandom), 16'($urandom), vc);
         if ($urandom_range(0, 2) == 0) begin
            // A fresh polyline with short hops so that chains stay compact.
            cx = int'($urandom_range(0, 8000)) - 4000;
            cy = int'($urandom_range(0, 8000)) - 4000;
            for (int i = 0; i < 16; i++) begin
               put_vertex(i, clamp(cx), clamp(cy));
               cx += int'($urandom_range(0, 1600)) - 800;
               cy += int'($urandom_range(0, 1600)) - 800;
            end
         end
         repeat (50) begin
            if ($urandom_range(0, 6) == 0) begin
               put_vertex($urandom_range(0, 15), rand_coord(), rand_coord());
            end else if ($urandom_range(0, 7) == 0) begin
               query(16'($urandom), 16'($urandom));
            end else begin
               v    = $urandom_range(0, 15);
               span = int'(ro) + int'(ro) / 4 + 32;
               query(clamp(shadow_x[v] + int'($urandom_range(0, 2 * span)) - span),
                     clamp(shadow_y[v] + int'($urandom_range(0, 2 * span)) - span));
            end
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off that backs up the block
   // while the sender is offering.
   initial begin
      int  cyc, g;
      logic held;
      cyc  = 0;
      held = 1'b0;
      rsp_ready <= 1'b0;
      repeat (10) @(posedge clock);
      forever begin
         if (cyc >= 3000 && !held && req_valid) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
            cyc += 600;
         end else if ($urandom_range(0, 3) == 0) begin
            g = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 4) : $urandom_range(20, 80);
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
            cyc += g;
         end
         g = $urandom_range(1, 30);
         rsp_ready <= 1'b1;
         repeat (g) @(posedge clock);
         cyc += g;
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
